FILE: src/bfsr_pkg.sv
// ============================================================================
// bfsr_pkg: shared definitions for the bounded queue with keyed removal
// Command and status codes, field widths and the capacity reset value.
// ============================================================================
package bfsr_pkg;

  // Field widths of the transaction payloads
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CAP_W    = 5;
  localparam int unsigned CNT_OUT_W = 5;

  // One stored entry is the key above the handle
  localparam int unsigned ENTRY_W  = KEY_W + HANDLE_W;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_TEST   = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

endpackage

FILE: src/bounded_fifo_with_search_remove.sv
// ============================================================================
// bounded_fifo_with_search_remove: bounded queue with keyed search and removal
// Entries live in a circular buffer in one RAM. A sequencer pushes, pops,
// scans for a key and closes the gap left by a removal, one RAM entry a cycle.
// ============================================================================
//
//   Channel   Handshake               Payload
//   -------   ---------------------   ------------------------------------------
//   in        in_valid / in_stall     in_cmd, in_item_value, in_item_handle
//   out       out_valid / out_stall   out_status, out_found, out_value,
//                                     out_handle, out_count
//   cfg       cfg_wr_en               cfg_wr_data (capacity)
//
// A push writes the RAM at acceptance and goes to the result stage; a pop reads
// the head at acceptance and takes the RAM read data in the pop state before the
// result stage. A test scans for the key and a remove also closes the gap: the
// key scan and the gap closing each walk the single RAM read port one entry a
// cycle. Reset is synchronous, clears the count and the head pointer and sets
// the capacity to 16; the RAM needs no clearing, since only entries below the
// count are used. A stalled output holds its result in the output register
// while the next transaction may already be accepted and worked on.
//
module bounded_fifo_with_search_remove #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bfsr_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [bfsr_pkg::KEY_W-1:0]   in_item_value,
  input  logic [bfsr_pkg::HANDLE_W-1:0]       in_item_handle,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bfsr_pkg::STATUS_W-1:0]       out_status,
  output logic                                out_found,
  output logic signed [bfsr_pkg::KEY_W-1:0]   out_value,
  output logic [bfsr_pkg::HANDLE_W-1:0]       out_handle,
  output logic [bfsr_pkg::CNT_OUT_W-1:0]      out_count,

  input  logic                                cfg_wr_en,
  input  logic [bfsr_pkg::CAP_W-1:0]          cfg_wr_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > bfsr_pkg::CAP_W) ? CW : bfsr_pkg::CAP_W;
  localparam logic [CW:0]   DEPTH_E   = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_POP   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  // Control registers
  state_t                       state_r, state_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [AW-1:0]                head_r, head_nxt;
  logic [CW-1:0]                idx_r, idx_nxt;
  logic [bfsr_pkg::CAP_W-1:0]   capacity_r, capacity_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // Payload registers
  logic [bfsr_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic                         rem_r, rem_nxt;
  bfsr_pkg::status_t            res_status_r, res_status_nxt;
  logic                         res_found_r, res_found_nxt;
  logic [bfsr_pkg::KEY_W-1:0]   res_value_r, res_value_nxt;
  logic [bfsr_pkg::HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  bfsr_pkg::status_t            out_status_r, out_status_nxt;
  logic                         out_found_r, out_found_nxt;
  logic [bfsr_pkg::KEY_W-1:0]   out_value_r, out_value_nxt;
  logic [bfsr_pkg::HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [bfsr_pkg::CNT_OUT_W-1:0] out_count_r, out_count_nxt;

  // RAM signals
  logic                          ram_wr_en;
  logic [AW-1:0]                 ram_wr_addr;
  logic [bfsr_pkg::ENTRY_W-1:0]  ram_wr_data;
  logic                          ram_rd_en;
  logic [AW-1:0]                 ram_rd_addr;
  logic [bfsr_pkg::ENTRY_W-1:0]  ram_rd_data;

  // Datapath helpers
  logic                          in_acc;
  logic                          out_load;
  logic                          full;
  logic                          scan_last;
  logic                          shift_last;
  logic                          key_match;
  logic [CW-1:0]                 rd_l;
  logic [CW-1:0]                 wr_l;
  logic [CW:0]                   rd_sum;
  logic [CW:0]                   wr_sum;
  logic [LW-1:0]                 count_e;

  // Entry store
  bfsr_ram #(
    .WIDTH (bfsr_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Handshakes
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // The queue is full at the configured capacity or at the RAM depth.
  assign count_e = LW'(count_r);
  assign full    = (count_e >= LW'(capacity_r)) || (count_r == DEPTH_C);

  // Scan and shift end tests
  assign scan_last  = (idx_r == count_r - CW'(1));
  assign shift_last = ((idx_r + CW'(2)) == count_r);
  assign key_match  = (ram_rd_data[bfsr_pkg::ENTRY_W-1:bfsr_pkg::HANDLE_W] == key_r);

  // Logical positions of the next read and of the write in this cycle
  always_comb begin
    if (state_r == S_IDLE) begin
      rd_l = '0;
    end else if (state_r == S_SHIFT) begin
      rd_l = idx_r + CW'(2);
    end else begin
      rd_l = idx_r + CW'(1);
    end
    wr_l = (state_r == S_SHIFT) ? idx_r : count_r;
  end

  // Logical position to RAM address, wrapping round the circular buffer
  always_comb begin
    rd_sum = (CW + 1)'(head_r) + {1'b0, rd_l};
    wr_sum = (CW + 1)'(head_r) + {1'b0, wr_l};
    ram_rd_addr = (rd_sum >= DEPTH_E) ? AW'(rd_sum - DEPTH_E) : AW'(rd_sum);
    ram_wr_addr = (wr_sum >= DEPTH_E) ? AW'(wr_sum - DEPTH_E) : AW'(wr_sum);
  end

  // RAM port control: pushes write at acceptance, the gap closing writes back
  // the entry read in the previous cycle one place nearer the head.
  always_comb begin
    ram_rd_en   = in_acc || (state_r == S_SCAN) || (state_r == S_SHIFT);
    ram_wr_en   = (in_acc && (in_cmd == bfsr_pkg::CMD_PUSH) && !full) ||
                  (state_r == S_SHIFT);
    ram_wr_data = (state_r == S_SHIFT) ? ram_rd_data : {in_item_value, in_item_handle};
  end

  // Sequencer and result assembly
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    idx_nxt        = idx_r;
    key_nxt        = key_r;
    rem_nxt        = rem_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_value_nxt  = res_value_r;
    res_handle_nxt = res_handle_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          key_nxt        = in_item_value;
          rem_nxt        = (in_cmd == bfsr_pkg::CMD_REMOVE);
          idx_nxt        = '0;
          res_status_nxt = bfsr_pkg::ST_DONE;
          res_found_nxt  = 1'b0;
          res_value_nxt  = '0;
          res_handle_nxt = '0;
          case (in_cmd)
            bfsr_pkg::CMD_PUSH: begin
              state_nxt = S_FIN;
              if (full) begin
                res_status_nxt = bfsr_pkg::ST_FULL;
              end else begin
                count_nxt = count_r + CW'(1);
              end
            end
            bfsr_pkg::CMD_POP: begin
              if (count_r == '0) begin
                res_status_nxt = bfsr_pkg::ST_EMPTY;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_POP;
              end
            end
            default: begin
              if (count_r == '0) begin
                res_status_nxt = bfsr_pkg::ST_NOTFOUND;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end

      // Head entry has arrived from the RAM
      S_POP: begin
        res_found_nxt  = 1'b1;
        res_value_nxt  = ram_rd_data[bfsr_pkg::ENTRY_W-1:bfsr_pkg::HANDLE_W];
        res_handle_nxt = ram_rd_data[bfsr_pkg::HANDLE_W-1:0];
        head_nxt       = (head_r == LAST_ADDR) ? '0 : head_r + AW'(1);
        count_nxt      = count_r - CW'(1);
        state_nxt      = S_FIN;
      end

      // Entry at position idx_r is on the read data; the next one is being read.
      S_SCAN: begin
        if (key_match) begin
          res_found_nxt = 1'b1;
          if (rem_r) begin
            res_value_nxt  = ram_rd_data[bfsr_pkg::ENTRY_W-1:bfsr_pkg::HANDLE_W];
            res_handle_nxt = ram_rd_data[bfsr_pkg::HANDLE_W-1:0];
            if (scan_last) begin
              count_nxt = count_r - CW'(1);
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_SHIFT;
            end
          end else begin
            state_nxt = S_FIN;
          end
        end else if (scan_last) begin
          res_status_nxt = bfsr_pkg::ST_NOTFOUND;
          state_nxt      = S_FIN;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end

      // Entry idx_r + 1 moves down to idx_r; the one after it is being read.
      S_SHIFT: begin
        if (shift_last) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end

      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register and capacity register
  always_comb begin
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_value_nxt  = out_value_r;
    out_handle_nxt = out_handle_r;
    out_count_nxt  = out_count_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_found_nxt  = res_found_r;
      out_value_nxt  = res_value_r;
      out_handle_nxt = res_handle_r;
      out_count_nxt  = count_e[bfsr_pkg::CNT_OUT_W-1:0];
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    capacity_nxt = cfg_wr_en ? cfg_wr_data : capacity_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      idx_r       <= '0;
      capacity_r  <= bfsr_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      idx_r       <= idx_nxt;
      capacity_r  <= capacity_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    rem_r        <= rem_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_value_r  <= res_value_nxt;
    res_handle_r <= res_handle_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_value_r  <= out_value_nxt;
    out_handle_r <= out_handle_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Result port
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_found  = out_found_r;
  assign out_value  = $signed(out_value_r);
  assign out_handle = out_handle_r;
  assign out_count  = out_count_r;

`ifndef SYNTH
  // The count never runs past the RAM depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count exceeds depth");

  // A scan or gap closing only ever touches held entries.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_SHIFT) |-> (idx_r < count_r))
    else $error("walk index outside held entries");

  // A push that is not refused adds exactly one entry.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == bfsr_pkg::CMD_PUSH && !full) |=>
      (count_r == $past(count_r) + CW'(1)))
    else $error("accepted push did not add one entry");
`endif

endmodule

FILE: src/bfsr_ram.sv
// ============================================================================
// bfsr_ram: generic single-clock RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the read address.
// ============================================================================
module bfsr_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
